// ===== sv/swt3q_pkg.sv =====
// ---------------------------------------------------------------------------
// swt3q_pkg: shared types and codes of the ranked stack
// result kinds, request modes and the controller/datapath interface structs
// ---------------------------------------------------------------------------
package swt3q_pkg;

	// request modes
	typedef enum logic [1:0] {
		MODE_PUSH = 2'd0,
		MODE_POP  = 2'd1,
		MODE_LIST = 2'd2,
		MODE_RANK = 2'd3
	} mode_t;

	// result kinds
	typedef enum logic [2:0] {
		KIND_PUSH  = 3'd0,
		KIND_POP   = 3'd1,
		KIND_LIST  = 3'd2,
		KIND_RANK  = 3'd3,
		KIND_EMPTY = 3'd4,
		KIND_FULL  = 3'd5
	} kind_t;

	// read address select
	typedef enum logic [1:0] {
		RD_TOP  = 2'd0,
		RD_ZERO = 2'd1,
		RD_DOWN = 2'd2,
		RD_UP   = 2'd3
	} rd_sel_t;

	typedef struct packed {
		logic [15:0]        tag;
		logic signed [15:0] score;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic    push_en;
		logic    full_en;
		logic    empty_en;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    pop_emit;
		logic    list_emit;
		logic    scan_en;
		logic    rank_init;
		logic    rank_emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic empty;
		logic full;
		logic ptr_zero;
		logic ptr_end;
		logic pass_last;
	} sts_t;

endpackage

// ===== sv/swt3q_ctrl.sv =====
// ---------------------------------------------------------------------------
// swt3q_ctrl: request sequencer
// decodes requests and steps the datapath through pop, list and ranking scans
// ---------------------------------------------------------------------------
module swt3q_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        mode,
	input  swt3q_pkg::sts_t   sts,
	output swt3q_pkg::cmd_t   cmd,
	output logic              busy
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POP,
		ST_LIST,
		ST_SCAN,
		ST_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   busy_q;

	always_comb begin
		cmd        = '0;
		cmd.rd_sel = swt3q_pkg::RD_ZERO;
		state_d    = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (mode == swt3q_pkg::MODE_PUSH) begin
						cmd.push_en = !sts.full;
						cmd.full_en = sts.full;
					end else if (sts.empty) begin
						cmd.empty_en = 1'b1;
					end else if (mode == swt3q_pkg::MODE_RANK) begin
						cmd.rd_en     = 1'b1;
						cmd.rd_sel    = swt3q_pkg::RD_ZERO;
						cmd.rank_init = 1'b1;
						state_d       = ST_SCAN;
					end else begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = swt3q_pkg::RD_TOP;
						state_d    = (mode == swt3q_pkg::MODE_POP) ? ST_POP : ST_LIST;
					end
				end
			end
			ST_POP: begin
				cmd.pop_emit = 1'b1;
				state_d      = ST_IDLE;
			end
			ST_LIST: begin
				cmd.list_emit = 1'b1;
				if (sts.ptr_zero) begin
					state_d = ST_IDLE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = swt3q_pkg::RD_DOWN;
				end
			end
			ST_SCAN: begin
				cmd.scan_en = 1'b1;
				if (sts.ptr_end) begin
					state_d = ST_EMIT;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = swt3q_pkg::RD_UP;
				end
			end
			ST_EMIT: begin
				cmd.rank_emit = 1'b1;
				if (sts.pass_last) begin
					state_d = ST_IDLE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = swt3q_pkg::RD_ZERO;
					state_d    = ST_SCAN;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != ST_IDLE);
		end
	end

	assign busy = busy_q;

endmodule

// ===== sv/swt3q_dpath.sv =====
// ---------------------------------------------------------------------------
// swt3q_dpath: entry memory, stack count, scan pointer and result registers
// one write and one registered read port on the entry memory
// ---------------------------------------------------------------------------
module swt3q_dpath #(
	parameter int DEPTH = 16,
	parameter int TOP_K = 3
) (
	input  logic                clk,
	input  logic                arst_n,
	input  swt3q_pkg::cmd_t     cmd,
	output swt3q_pkg::sts_t     sts,
	input  logic [15:0]         name_tag,
	input  logic signed [15:0]  score,
	output logic                strobe,
	output logic [2:0]          kind,
	output logic [15:0]         out_tag,
	output logic signed [15:0]  out_score,
	output logic                last
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (TOP_K > 1) ? $clog2(TOP_K) : 1;

	swt3q_pkg::entry_t mem [DEPTH];
	swt3q_pkg::entry_t rdata_q;
	swt3q_pkg::entry_t best_q;
	logic [AW-1:0]     bidx_q;
	logic              found_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     count_m1;
	logic [AW-1:0]     ptr_q;
	logic [AW-1:0]     raddr;
	logic [PW-1:0]     pass_q;
	logic [DEPTH-1:0]  taken_q;
	logic              strobe_q;
	swt3q_pkg::kind_t  kind_q;
	logic [15:0]       tag_q;
	logic signed [15:0] score_q;
	logic              last_q;

	assign count_m1 = count_q - CW'(1);

	always_comb begin
		case (cmd.rd_sel)
			swt3q_pkg::RD_TOP:  raddr = count_m1[AW-1:0];
			swt3q_pkg::RD_ZERO: raddr = '0;
			swt3q_pkg::RD_DOWN: raddr = ptr_q - AW'(1);
			swt3q_pkg::RD_UP:   raddr = ptr_q + AW'(1);
			default:            raddr = '0;
		endcase
	end

	assign sts.empty     = (count_q == '0);
	assign sts.full      = (count_q == CW'(DEPTH));
	assign sts.ptr_zero  = (ptr_q == '0);
	assign sts.ptr_end   = (CW'(ptr_q) == count_m1);
	assign sts.pass_last = ((CW'(pass_q) + CW'(1)) == count_q) ||
		(pass_q == PW'(TOP_K - 1));

	// entry memory
	always_ff @(posedge clk) begin
		if (cmd.push_en) begin
			mem[count_q[AW-1:0]] <= '{tag: name_tag, score: score};
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	// stack count and ranking control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ptr_q   <= '0;
			pass_q  <= '0;
			found_q <= 1'b0;
			taken_q <= '0;
		end else begin
			if (cmd.push_en) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.pop_emit) begin
				count_q <= count_m1;
			end
			if (cmd.rd_en) begin
				ptr_q <= raddr;
			end
			if (cmd.rank_init) begin
				pass_q  <= '0;
				found_q <= 1'b0;
				taken_q <= '0;
			end else if (cmd.rank_emit) begin
				pass_q          <= pass_q + PW'(1);
				found_q         <= 1'b0;
				taken_q[bidx_q] <= 1'b1;
			end else if (cmd.scan_en && !taken_q[ptr_q] &&
				(!found_q || ($signed(rdata_q.score) > $signed(best_q.score)))) begin
				found_q <= 1'b1;
			end
		end
	end

	// best candidate of the running pass; strict compare keeps the older entry
	always_ff @(posedge clk) begin
		if (cmd.scan_en && !taken_q[ptr_q] &&
			(!found_q || ($signed(rdata_q.score) > $signed(best_q.score)))) begin
			best_q <= rdata_q;
			bidx_q <= ptr_q;
		end
	end

	// result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.push_en | cmd.full_en | cmd.empty_en |
				cmd.pop_emit | cmd.list_emit | cmd.rank_emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push_en || cmd.full_en) begin
			kind_q  <= cmd.push_en ? swt3q_pkg::KIND_PUSH : swt3q_pkg::KIND_FULL;
			tag_q   <= name_tag;
			score_q <= score;
			last_q  <= 1'b1;
		end else if (cmd.empty_en) begin
			kind_q  <= swt3q_pkg::KIND_EMPTY;
			tag_q   <= '0;
			score_q <= '0;
			last_q  <= 1'b1;
		end else if (cmd.pop_emit || cmd.list_emit) begin
			kind_q  <= cmd.pop_emit ? swt3q_pkg::KIND_POP : swt3q_pkg::KIND_LIST;
			tag_q   <= rdata_q.tag;
			score_q <= rdata_q.score;
			last_q  <= cmd.pop_emit | sts.ptr_zero;
		end else if (cmd.rank_emit) begin
			kind_q  <= swt3q_pkg::KIND_RANK;
			tag_q   <= best_q.tag;
			score_q <= best_q.score;
			last_q  <= sts.pass_last;
		end
	end

	assign strobe    = strobe_q;
	assign kind      = kind_q;
	assign out_tag   = tag_q;
	assign out_score = score_q;
	assign last      = last_q;

endmodule

// ===== sv/stack_with_top3_query_top.sv =====
// ---------------------------------------------------------------------------
// stack_with_top3_query_top: bounded stack of tagged scores with top-k ranking
//
// requests: start with mode, name_tag and score; a request is taken at a rising
//   edge with start high and busy low
// results: strobe marks one result for exactly one cycle on kind, out_tag,
//   out_score and last; last flags the final result of a request's run
// timing: a push, or any request on an empty stack, strobes its result in the
//   cycle right after the accepting edge; pop and list results follow the entry
//   read and the pop or list state; the first ranked result follows a scan of the stored entries and an emit state
// occupancy: push (and any request on an empty stack) leaves busy low; pop and
//   list hold busy until their last result; top-k holds busy for min(count, TOP_K)
//   passes, each pass a scan of the stored entries through the entry memory's
//   single registered read port plus an emit state
// reset: arst_n empties the stack and drops any result in flight; stored
//   entries are not cleared and need no clearing pass
// the receiver cannot stall, so results are never held back
// ---------------------------------------------------------------------------
module stack_with_top3_query_top #(
	parameter int DEPTH = 16,
	parameter int TOP_K = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         mode,
	input  logic [15:0]        name_tag,
	input  logic signed [15:0] score,
	output logic               strobe,
	output logic [2:0]         kind,
	output logic [15:0]        out_tag,
	output logic signed [15:0] out_score,
	output logic               last
);

	// command and status between sequencer and datapath
	swt3q_pkg::cmd_t cmd;
	swt3q_pkg::sts_t sts;

	// sequencer: request decode, list walk and ranking passes
	swt3q_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// datapath: entry memory, count, scan state and result registers
	swt3q_dpath #(
		.DEPTH (DEPTH),
		.TOP_K (TOP_K)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.name_tag  (name_tag),
		.score     (score),
		.strobe    (strobe),
		.kind      (kind),
		.out_tag   (out_tag),
		.out_score (out_score),
		.last      (last)
	);

endmodule

// ===== sv/swt3q_checker.sv =====
// ---------------------------------------------------------------------------
// swt3q_checker: port-level checks of the ranked stack
// request decode timing and run framing seen from the top level ports
// ---------------------------------------------------------------------------
module swt3q_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] mode,
	input logic       strobe,
	input logic [2:0] kind,
	input logic       last
);

	// a push gets its ack or full result in the very next cycle
	a_push_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && mode == swt3q_pkg::MODE_PUSH) |=>
		(strobe && (kind == swt3q_pkg::KIND_PUSH || kind == swt3q_pkg::KIND_FULL)))
		else $error("push request without ack or full result");

	// other requests either report empty at once or hold the block busy
	a_other_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && mode != swt3q_pkg::MODE_PUSH) |=>
		(busy || (strobe && kind == swt3q_pkg::KIND_EMPTY)))
		else $error("request neither busy nor reported empty");

	// single-result kinds always close their run
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && (kind == swt3q_pkg::KIND_PUSH || kind == swt3q_pkg::KIND_POP ||
		kind == swt3q_pkg::KIND_EMPTY || kind == swt3q_pkg::KIND_FULL)) |-> last)
		else $error("single result without last");

	// the block frees up exactly with the final result of a run
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (last == !busy))
		else $error("busy does not match run framing");

endmodule

bind stack_with_top3_query_top swt3q_checker u_swt3q_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.mode   (mode),
	.strobe (strobe),
	.kind   (kind),
	.last   (last)
);
